// ===== design/esp_pkg.sv =====
// Shared types, constants and coefficient table for the elliptical Sersic pixel adder.
package esp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_COEF_XX   = 3'd0,
        REG_COEF_YY   = 3'd1,
        REG_COEF_XY   = 3'd2,
        REG_CENTER_X  = 3'd3,
        REG_CENTER_Y  = 3'd4,
        REG_AMPLITUDE = 3'd5,
        REG_EXPONENT  = 3'd6
    } t_reg_idx;

    localparam logic [15:0] EXPONENT_RESET = 16'd4096;
    localparam logic [31:0] ONE_Q30        = 32'd1073741824;
    localparam logic [28:0] LOG2E_Q28      = 29'd387270501;

    typedef struct packed {
        logic [11:0]        column;
        logic [11:0]        row;
        logic signed [31:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pixel_out;
        logic               form_negative;
    } t_out_item;

    // Per-pixel context that rides along the whole pipe
    typedef struct packed {
        logic signed [31:0] pix;
        logic               pass;   // leave pixel unchanged
        logic               neg;    // quadratic form negative
        logic               qz;     // quadratic form zero
        logic [5:0]         k;      // top set bit of q
        logic               pone;   // power forced to one
        logic signed [11:0] n;      // integer part of the power exponent
        logic               rone;   // result forced to one
        logic [7:0]         sh;     // final exp2 right shift
    } t_side;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic        sx;
        logic        sy;
        t_side       sd;
    } t_s0;

    typedef struct packed {
        logic [31:0] uxx;
        logic [31:0] uyy;
        logic [31:0] uxy;
        logic        cneg;
        t_side       sd;
    } t_s1;

    typedef struct packed {
        logic [47:0] txx;
        logic [47:0] tyy;
        logic [47:0] tc;
        logic        cneg;
        t_side       sd;
    } t_s2;

    typedef struct packed {
        logic [49:0] q;
        t_side       sd;
    } t_s3;

    // Log2 squaring cell payload
    typedef struct packed {
        logic [30:0] m;
        logic [15:0] frac;
        t_side       sd;
    } t_lg;

    // Horner cell payload
    typedef struct packed {
        logic [31:0] acc;
        logic [30:0] g;
        t_side       sd;
    } t_hn;

    typedef struct packed {
        logic [35:0] p;
        t_side       sd;
    } t_s7;

    typedef struct packed {
        logic [60:0] plo;
        logic [32:0] phi;
        t_side       sd;
    } t_s8;

    typedef struct packed {
        logic [31:0] r;
        t_side       sd;
    } t_s10;

    typedef struct packed {
        logic [33:0] f;
        t_side       sd;
    } t_s11;

    // Q1.30 Taylor coefficients (ln2)^i / i!
    function automatic logic [31:0] exp2_coef(input int idx);
        logic [31:0] c;
        case (idx)
            0:       c = 32'd1073741824;
            1:       c = 32'd744261118;
            2:       c = 32'd257941248;
            3:       c = 32'd59597083;
            4:       c = 32'd10327388;
            5:       c = 32'd1431680;
            6:       c = 32'd165394;
            7:       c = 32'd16378;
            default: c = 32'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/esp_sq_cell.sv =====
// Log2 fraction cell: one squaring step producing one fraction bit.
module esp_sq_cell
    import esp_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_lg  i_d,
    output t_lg  o_q
);

    logic [61:0] sq;
    logic [31:0] sq_sh;
    t_lg         n_q;
    t_lg         r_q;

    always_comb begin
        sq       = {31'b0, i_d.m} * {31'b0, i_d.m};
        sq_sh    = sq[61:30];
        n_q      = i_d;
        n_q.m    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
        n_q.frac = {i_d.frac[14:0], sq_sh[31]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/esp_horner_cell.sv =====
// Horner cell: one multiply-add step of the exp2 polynomial.
module esp_horner_cell
    import esp_pkg::*;
#(
    parameter int COEF_IDX = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_hn  i_d,
    output t_hn  o_q
);

    localparam logic [31:0] COEF = exp2_coef(COEF_IDX);

    logic [62:0] prod;
    t_hn         n_q;
    t_hn         r_q;

    always_comb begin
        prod    = {31'b0, i_d.acc} * {32'b0, i_d.g};
        n_q     = i_d;
        n_q.acc = COEF + prod[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/elliptical_sersic_pixel_adder.sv =====
// Top level: streaming elliptical Sersic profile adder, one pixel per transfer.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries column, row and the
//   present pixel value. Output channel (o_out_valid / i_out_ready / o_out_data)
//   returns the pixel with amplitude*exp(-q^alpha) added, saturated, plus a flag
//   when the quadratic form q is negative (pixel then passes unchanged).
//   Configuration goes through a plain write port (i_cfg_wr_en, i_cfg_index,
//   i_cfg_wdata); write it only while no pixel is in flight.
// Timing
//   Throughput is one pixel per cycle while the output register is not stuck: the
//   pipe is a chain of registered cells (16 log2 squaring cells, two rows of 7
//   Horner cells for exp2) and each cell takes a new item every cycle unless the
//   pipe holds (see Back-pressure).
// Reset
//   Synchronous, active low. Clears all valid bits and the configuration
//   registers (exponent resets to 1.0, all others to zero).
// Back-pressure
//   The final stage is the output register. When it holds a result that is not
//   taken, the whole pipe holds and o_in_ready drops; pixels in flight are kept.
module elliptical_sersic_pixel_adder
    import esp_pkg::*;
#(
    parameter int IMAGE_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // pixel output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int          NST = 43;
    localparam int          NLG = 16;
    localparam int          NHN = 7;
    localparam logic [16:0] DIM = 17'(IMAGE_DIM);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0]        r_coef_xx;
    logic [31:0]        r_coef_yy;
    logic signed [31:0] r_coef_xy;
    logic [15:0]        r_center_x;
    logic [15:0]        r_center_y;
    logic signed [31:0] r_amplitude;
    logic [15:0]        r_exponent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx   <= '0;
            r_coef_yy   <= '0;
            r_coef_xy   <= '0;
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_amplitude <= '0;
            r_exponent  <= EXPONENT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_COEF_XX:   r_coef_xx   <= i_cfg_wdata;
                REG_COEF_YY:   r_coef_yy   <= i_cfg_wdata;
                REG_COEF_XY:   r_coef_xy   <= i_cfg_wdata;
                REG_CENTER_X:  r_center_x  <= i_cfg_wdata[15:0];
                REG_CENTER_Y:  r_center_y  <= i_cfg_wdata[15:0];
                REG_AMPLITUDE: r_amplitude <= i_cfg_wdata;
                REG_EXPONENT:  r_exponent  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Magnitudes of the signed registers (-2^31 maps to 2^31 unsigned)
    logic [31:0] coef_xy_mag;
    logic [31:0] amp_mag;
    assign coef_xy_mag = r_coef_xy[31] ? 32'(-r_coef_xy) : r_coef_xy;
    assign amp_mag     = r_amplitude[31] ? 32'(-r_amplitude) : r_amplitude;

    // ------------------------------------------------------------------
    // Flow control: whole pipe advances unless the output register is stuck
    // ------------------------------------------------------------------
    logic           en;
    logic [NST-1:0] r_v;

    assign en          = !r_v[NST-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_in_valid};
        end
    end

    // ------------------------------------------------------------------
    // S0: offsets from the centre in sixteenths of a pixel
    // ------------------------------------------------------------------
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [17:0]        ndx;
    logic [17:0]        ndy;
    t_s0                n_s0;
    t_s0                r_s0;

    always_comb begin
        dx          = $signed({2'b0, i_in_data.column, 4'h8}) - $signed({2'b0, r_center_x});
        dy          = $signed({2'b0, i_in_data.row, 4'h8}) - $signed({2'b0, r_center_y});
        ndx         = 18'(-dx);
        ndy         = 18'(-dy);
        n_s0        = '0;
        n_s0.ux     = dx[17] ? ndx[15:0] : dx[15:0];
        n_s0.uy     = dy[17] ? ndy[15:0] : dy[15:0];
        n_s0.sx     = dx[17];
        n_s0.sy     = dy[17];
        n_s0.sd.pix = i_in_data.pixel_in;
        // outside the image: pass unchanged, no flag
        n_s0.sd.pass = ({5'b0, i_in_data.column} >= DIM) || ({5'b0, i_in_data.row} >= DIM);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
        end
    end

    // ------------------------------------------------------------------
    // S1: squares and cross product of the offset magnitudes
    // ------------------------------------------------------------------
    t_s1 n_s1;
    t_s1 r_s1;

    always_comb begin
        n_s1.uxx  = {16'b0, r_s0.ux} * {16'b0, r_s0.ux};
        n_s1.uyy  = {16'b0, r_s0.uy} * {16'b0, r_s0.uy};
        n_s1.uxy  = {16'b0, r_s0.ux} * {16'b0, r_s0.uy};
        n_s1.cneg = r_s0.sx ^ r_s0.sy ^ r_coef_xy[31];
        n_s1.sd   = r_s0.sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // S2: coefficient products, truncated to units of 2^-20
    // ------------------------------------------------------------------
    logic [63:0] pxx;
    logic [63:0] pyy;
    logic [63:0] pxy;
    t_s2         n_s2;
    t_s2         r_s2;

    always_comb begin
        pxx       = {32'b0, r_coef_xx} * {32'b0, r_s1.uxx};
        pyy       = {32'b0, r_coef_yy} * {32'b0, r_s1.uyy};
        pxy       = {32'b0, coef_xy_mag} * {32'b0, r_s1.uxy};
        n_s2.txx  = pxx[63:16];
        n_s2.tyy  = pyy[63:16];
        n_s2.tc   = pxy[63:16];
        n_s2.cneg = r_s1.cneg;
        n_s2.sd   = r_s1.sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= n_s2;
        end
    end

    // ------------------------------------------------------------------
    // S3: quadratic form, sign and zero detect
    // ------------------------------------------------------------------
    logic signed [50:0] tc_s;
    logic signed [50:0] q_s;
    t_s3                n_s3;
    t_s3                r_s3;

    always_comb begin
        tc_s       = $signed({3'b0, r_s2.tc});
        q_s        = $signed({3'b0, r_s2.txx}) + $signed({3'b0, r_s2.tyy})
                   + (r_s2.cneg ? -tc_s : tc_s);
        n_s3.q     = q_s[49:0];
        n_s3.sd    = r_s2.sd;
        n_s3.sd.qz = (q_s == '0);
        if (q_s[50] && !r_s2.sd.pass) begin
            n_s3.sd.neg  = 1'b1;
            n_s3.sd.pass = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3 <= n_s3;
        end
    end

    // ------------------------------------------------------------------
    // S4: position of the top set bit of q
    // ------------------------------------------------------------------
    logic [5:0] kpos;
    t_s3        n_s4;
    t_s3        r_s4;

    always_comb begin
        kpos = '0;
        for (int i = 0; i < 50; i++) begin
            if (r_s3.q[i]) begin
                kpos = 6'(i);
            end
        end
        n_s4      = r_s3;
        n_s4.sd.k = kpos;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4 <= n_s4;
        end
    end

    // ------------------------------------------------------------------
    // S5: normalize q to a Q1.30 mantissa, feed the log2 cell row
    // ------------------------------------------------------------------
    logic [49:0] qnorm;
    t_lg         n_s5;
    t_lg         lg [NLG+1];

    always_comb begin
        qnorm     = r_s4.q << (6'd49 - r_s4.sd.k);
        n_s5.m    = qnorm[49:19];
        n_s5.frac = '0;
        n_s5.sd   = r_s4.sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            lg[0] <= n_s5;
        end
    end

    for (genvar gi = 0; gi < NLG; gi++) begin : g_lg
        esp_sq_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (lg[gi]),
            .o_q   (lg[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // S6: y = exponent * log2(q), split into integer and fraction
    // ------------------------------------------------------------------
    logic signed [6:0]  kk;
    logic signed [22:0] lq;
    logic signed [39:0] yp;
    logic signed [27:0] yv;
    logic               big;
    t_hn                n_s6;
    t_hn                ha [NHN+1];

    always_comb begin
        kk           = $signed({1'b0, lg[NLG].sd.k}) - 7'sd20;
        lq           = $signed({kk, lg[NLG].frac});
        yp           = $signed({1'b0, r_exponent}) * lq;
        yv           = yp[39:12];
        big          = yv >= 28'sd327680;
        n_s6.acc     = exp2_coef(7);
        n_s6.g       = {1'b0, yv[15:0], 14'b0};
        n_s6.sd      = lg[NLG].sd;
        n_s6.sd.n    = yv[27:16];
        n_s6.sd.pone = (r_exponent == '0);
        // power too large: result underflows, drop the model value
        if (big && (r_exponent != '0) && !lg[NLG].sd.qz) begin
            n_s6.sd.pass = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ha[0] <= n_s6;
        end
    end

    for (genvar gi = 0; gi < NHN; gi++) begin : g_ha
        esp_horner_cell #(
            .COEF_IDX (NHN - 1 - gi)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (ha[gi]),
            .o_q   (ha[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // S7: p = q^alpha in Q.30
    // ------------------------------------------------------------------
    logic [11:0] nneg;
    t_s7         n_s7;
    t_s7         r_s7;

    always_comb begin
        nneg    = 12'(-ha[NHN].sd.n);
        n_s7.sd = ha[NHN].sd;
        if (ha[NHN].sd.pone) begin
            n_s7.p = {4'b0, ONE_Q30};
        end else if (ha[NHN].sd.qz) begin
            n_s7.p = '0;
        end else if (!ha[NHN].sd.n[11]) begin
            n_s7.p = {4'b0, ha[NHN].acc} << ha[NHN].sd.n[2:0];
        end else if (ha[NHN].sd.n < -12'sd39) begin
            n_s7.p = '0;
        end else begin
            n_s7.p = {4'b0, ha[NHN].acc} >> nneg[5:0];
        end
        n_s7.sd.rone = (n_s7.p == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7 <= n_s7;
        end
    end

    // ------------------------------------------------------------------
    // S8: p * log2(e), as two partial products
    // ------------------------------------------------------------------
    t_s8 n_s8;
    t_s8 r_s8;

    always_comb begin
        n_s8.plo = {29'b0, r_s7.p[31:0]} * {32'b0, LOG2E_Q28};
        n_s8.phi = {29'b0, r_s7.p[35:32]} * {4'b0, LOG2E_Q28};
        n_s8.sd  = r_s7.sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8 <= n_s8;
        end
    end

    // ------------------------------------------------------------------
    // S9: z = n + fr; feed exp2(1 - fr) into the second Horner row
    // ------------------------------------------------------------------
    logic [64:0] zfull;
    logic [36:0] zv;
    t_hn         n_s9;
    t_hn         hb [NHN+1];

    always_comb begin
        zfull      = {r_s8.phi, 32'b0} + {4'b0, r_s8.plo};
        zv         = zfull[64:28];
        n_s9.acc   = exp2_coef(7);
        n_s9.g     = ONE_Q30[30:0] - {1'b0, zv[29:0]};
        n_s9.sd    = r_s8.sd;
        n_s9.sd.sh = {1'b0, zv[36:30]} + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            hb[0] <= n_s9;
        end
    end

    for (genvar gi = 0; gi < NHN; gi++) begin : g_hb
        esp_horner_cell #(
            .COEF_IDX (NHN - 1 - gi)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (hb[gi]),
            .o_q   (hb[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // S10: r = exp(-p) in Q.30
    // ------------------------------------------------------------------
    t_s10 n_s10;
    t_s10 r_s10;

    always_comb begin
        n_s10.sd = hb[NHN].sd;
        if (hb[NHN].sd.rone) begin
            n_s10.r = ONE_Q30;
        end else if (hb[NHN].sd.sh >= 8'd62) begin
            n_s10.r = '0;
        end else begin
            n_s10.r = hb[NHN].acc >> hb[NHN].sd.sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s10 <= n_s10;
        end
    end

    // ------------------------------------------------------------------
    // S11: model value magnitude |amplitude| * r >> 30
    // ------------------------------------------------------------------
    logic [63:0] fprod;
    t_s11        n_s11;
    t_s11        r_s11;

    always_comb begin
        fprod    = {32'b0, amp_mag} * {32'b0, r_s10.r};
        n_s11.f  = r_s10.sd.pass ? 34'b0 : fprod[63:30];
        n_s11.sd = r_s10.sd;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s11 <= n_s11;
        end
    end

    // ------------------------------------------------------------------
    // S12: signed add with saturation into the output register
    // ------------------------------------------------------------------
    logic signed [35:0] fs;
    logic signed [35:0] sum;
    t_out_item          n_out;
    t_out_item          r_out;

    always_comb begin
        fs  = $signed({2'b0, r_s11.f});
        sum = 36'(r_s11.sd.pix) + (r_amplitude[31] ? -fs : fs);
        if (r_s11.sd.pass) begin
            n_out.pixel_out = r_s11.sd.pix;
        end else if (sum > 36'sd2147483647) begin
            n_out.pixel_out = 32'sh7FFFFFFF;
        end else if (sum < -36'sd2147483648) begin
            n_out.pixel_out = 32'sh80000000;
        end else begin
            n_out.pixel_out = sum[31:0];
        end
        n_out.form_negative = r_s11.sd.neg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== verif/pixel_adder_checker.sv =====
// Watches the pixel and configuration ports, predicts each output pixel, and compares.
`timescale 1ns / 100ps
module pixel_adder_checker
    import esp_pkg::*;
#(
    parameter int IMAGE_DIM = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [31:0]        coef_a, coef_b;
    logic signed [31:0] coef_c, peak;
    logic [15:0]        cen_x, cen_y, alpha;
    t_out_item          pixel_due[$];
    int                 fails;

    // Horner evaluation of 2^g, g in Q.30
    function automatic logic [63:0] pow2_frac(logic [63:0] g);
        logic [63:0] acc;
        acc = 64'(exp2_coef(7));
        for (int i = 6; i >= 0; i--)
            acc = 64'(exp2_coef(i)) + ((acc * g) >> 30);
        return acc;
    endfunction

    // log2 of a positive form value (units 2^-20), result Q.16
    function automatic longint log2_form(logic [63:0] q);
        int          k;
        logic [63:0] m;
        longint      frac;
        k = 0;
        frac = 0;
        while (k < 63 && (q >> (k + 1)) != 0) k++;
        m = (k >= 30) ? (q >> (k - 30)) : (q << (30 - k));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 2 * 64'(ONE_Q30)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(k - 20) * 65536 + frac;
    endfunction

    function automatic t_out_item profile_sum(t_in_item it);
        t_out_item   res;
        longint      dx, dy, q, y, n, f, sum, cl, pk;
        logic [63:0] ux, uy, uc, txx, tyy, tc, p, m, z, zn, fr, e, r, up;
        logic        cneg;
        res.pixel_out = it.pixel_in;
        res.form_negative = 1'b0;
        if (it.column >= IMAGE_DIM || it.row >= IMAGE_DIM) return res;
        dx = longint'(it.column) * 16 + 8 - longint'(cen_x);
        dy = longint'(it.row) * 16 + 8 - longint'(cen_y);
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        cl = coef_c;
        uc = (cl < 0) ? -cl : cl;
        txx = (64'(coef_a) * (ux * ux)) >> 16;
        tyy = (64'(coef_b) * (uy * uy)) >> 16;
        tc  = (uc * (ux * uy)) >> 16;
        cneg = ((dx < 0) != (dy < 0)) != (cl < 0);
        q = longint'(txx) + longint'(tyy) + (cneg ? -longint'(tc) : longint'(tc));
        if (q < 0) begin
            res.form_negative = 1'b1;
            return res;
        end
        if (alpha == 0) begin
            p = 64'(ONE_Q30);
        end else if (q == 0) begin
            p = 0;
        end else begin
            y = (longint'(alpha) * log2_form(q)) >>> 12;
            // power too large: model value vanishes
            if (y >= 5 * 65536) return res;
            n = y >>> 16;
            m = pow2_frac(64'(y - n * 65536) << 14);
            if (n >= 0) p = m << n;
            else if (n < -39) p = 0;
            else p = m >> (-n);
        end
        if (p == 0) begin
            r = 64'(ONE_Q30);
        end else begin
            z  = (p * 64'(LOG2E_Q28)) >> 28;
            zn = z >> 30;
            fr = z & (64'(ONE_Q30) - 1);
            e  = pow2_frac(64'(ONE_Q30) - fr);
            r  = (zn + 1 >= 62) ? 64'd0 : (e >> (zn + 1));
        end
        pk = peak;
        up = (pk < 0) ? -pk : pk;
        f = longint'((up * r) >> 30);
        if (pk < 0) f = -f;
        sum = longint'(it.pixel_in) + f;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        res.pixel_out = sum[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            coef_a <= '0;
            coef_b <= '0;
            coef_c <= '0;
            cen_x  <= '0;
            cen_y  <= '0;
            peak   <= '0;
            alpha  <= EXPONENT_RESET;
            pixel_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_COEF_XX:   coef_a <= i_cfg_wdata;
                    REG_COEF_YY:   coef_b <= i_cfg_wdata;
                    REG_COEF_XY:   coef_c <= i_cfg_wdata;
                    REG_CENTER_X:  cen_x  <= i_cfg_wdata[15:0];
                    REG_CENTER_Y:  cen_y  <= i_cfg_wdata[15:0];
                    REG_AMPLITUDE: peak   <= i_cfg_wdata;
                    REG_EXPONENT:  alpha  <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                pixel_due.push_back(profile_sum(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pixel_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: unexpected output pixel %h flag %b",
                                 i_out_data.pixel_out, i_out_data.form_negative);
                end else begin
                    want = pixel_due.pop_front();
                    if (want.pixel_out !== i_out_data.pixel_out ||
                        want.form_negative !== i_out_data.form_negative) begin
                        fails++;
                        if (fails <= 10)
                            $display("checker: mismatch pixel exp %h got %h, flag exp %b got %b",
                                     want.pixel_out, i_out_data.pixel_out,
                                     want.form_negative, i_out_data.form_negative);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= pixel_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the pixel adder testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module testbench;
    import esp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CENTER_PIX  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;

    int fail_count;
    int pending;
    int cycle_cnt;
    int pixels_sent;
    int settings_used;
    int burst_left;
    int stall_mode;
    int stall_left;

    elliptical_sersic_pixel_adder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    pixel_adder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the pipe wedges
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: switch between stall patterns at random intervals, including
    // long stretches of steady ready so the pipe also runs at full rate
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            2:       i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= (cycle_cnt % 5 != 0);
        endcase
    end

    // Drain the pipe, then write one register per cycle with no pixel in flight
    task automatic load_settings(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [15:0] cx, logic [15:0] cy, logic [31:0] amp,
                                 logic [15:0] alpha);
        logic [31:0] vals [7];
        vals = '{a, b, c, 32'(cx), 32'(cy), amp, 32'(alpha)};
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int i = 0; i < 7; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Present one pixel; bursts of random length separated by random gaps
    task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] pix);
        t_in_item it;
        it.column   = col;
        it.row      = row;
        it.pixel_in = pix;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(($urandom_range(0, 255) << 16));
            default: return $urandom;
        endcase
    endfunction

    // Random setting: mostly profiles a few dozen pixels wide, now and then
    // wild coefficients, exponents and amplitudes
    task automatic random_settings(output int cpx, output int cpy);
        logic [31:0] a, b, c, amp;
        logic [15:0] alpha, cx, cy;
        int          lim;
        a = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8000000);
        b = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8000000);
        lim = (a < b) ? a : b;
        if (lim > 32'h3FFF_FFFF) lim = 32'h3FFF_FFFF;
        c = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, lim) -
                                                        $urandom_range(0, lim));
        cpx = $urandom_range(0, 4095);
        cpy = $urandom_range(0, 4095);
        cx = 16'($urandom_range(0, 15) + 16 * cpx);
        cy = 16'($urandom_range(0, 15) + 16 * cpy);
        case ($urandom_range(0, 5))
            0:       alpha = 16'($urandom);
            1:       alpha = 16'd0;
            default: alpha = 16'($urandom_range(1024, 12288));
        endcase
        amp = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 200) -
                                                             100) <<< 16);
        load_settings(a, b, c, cx, cy, amp, alpha);
    endtask

    initial begin
        int cpx, cpy, col, row;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        cycle_cnt   = 0;
        pixels_sent = 0;
        settings_used = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_left  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all coefficients zero, so every pixel sits at q == 0
        send_pixel(12'd0, 12'd0, 32'h0001_0000);
        send_pixel(12'hFFF, 12'hFFF, 32'h8000_0000);
        stop_sending();

        // Round profile at pixel 100: peak, saturation at both ends, corners
        load_settings(32'd2700000, 32'd2700000, 32'd0, 16'(16 * CENTER_PIX + 8),
                      16'(16 * CENTER_PIX + 8), 32'h7FFF_FFFF, 16'd4096);
        send_pixel(12'(CENTER_PIX), 12'(CENTER_PIX), 32'h7FFF_FFFF);
        send_pixel(12'(CENTER_PIX), 12'(CENTER_PIX), 32'h8000_0000);
        send_pixel(12'(CENTER_PIX + 3), 12'(CENTER_PIX - 2), 32'h0000_0000);
        send_pixel(12'(CENTER_PIX + 20), 12'(CENTER_PIX), 32'hFFFF_0000);
        send_pixel(12'd0, 12'd0, 32'h1234_5678);
        send_pixel(12'hFFF, 12'hFFF, 32'h0000_0001);
        send_pixel(12'hFFF, 12'd0, 32'h7FFF_0000);
        stop_sending();

        // Pure cross term, most negative: the form goes negative in two
        // quadrants; zero exponent pins the power to one elsewhere
        load_settings(32'd0, 32'd0, 32'h8000_0000, 16'(16 * CENTER_PIX),
                      16'(16 * CENTER_PIX), 32'h8000_0000, 16'd0);
        send_pixel(12'(CENTER_PIX + 5), 12'(CENTER_PIX + 5), 32'h0000_0000);
        send_pixel(12'(CENTER_PIX - 5), 12'(CENTER_PIX + 5), 32'h8000_0000);
        send_pixel(12'(CENTER_PIX + 5), 12'(CENTER_PIX - 9), 32'h7FFF_FFFF);
        send_pixel(12'(CENTER_PIX - 5), 12'(CENTER_PIX - 5), 32'h0000_0000);
        stop_sending();

        // Tiny coefficients and the largest exponent: the power underflows
        load_settings(32'd1, 32'd1, 32'd0, 16'd0, 16'd0, 32'h1234_5678, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'(CENTER_PIX), 12'd0, 32'h0000_0000);
        send_pixel(12'hFFF, 12'hFFF, 32'h7FFF_FFFF);
        stop_sending();

        // Largest coefficients from the far corner: the power overflows
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF,
                      32'h7FFF_FFFF, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'hFFF, 12'hFFF, 32'h8000_0000);
        send_pixel(12'hFFE, 12'hFFF, 32'h0000_0000);
        stop_sending();

        // Random settings, each followed by a batch of pixels clustered on the
        // profile with some scattered over the whole image
        for (int ph = 0; ph < 8; ph++) begin
            random_settings(cpx, cpy);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end else begin
                    col = cpx + $urandom_range(0, 80) - 40;
                    row = cpy + $urandom_range(0, 80) - 40;
                    col = (col < 0) ? 0 : ((col > 4095) ? 4095 : col);
                    row = (row < 0) ? 0 : ((row > 4095) ? 4095 : row);
                end
                send_pixel(12'(col), 12'(row), rand_pixel());
            end
            stop_sending();
        end

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("testbench: %0d pixels through %0d register settings, including zero,",
                 pixels_sent, settings_used);
        $display("testbench: negative, underflowing and overflowing forms and saturation");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
